/* hdl/cas_pkg.sv */
// Package with the phase codes, channel payload types and register indexes of the choke sequencer.
`default_nettype none
package cas_pkg;

	// Sequencer phases; the code is visible on the phase_code output.
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_INIT_UP   = 4'd1,
		PH_INIT_SET1 = 4'd2,
		PH_INIT_DOWN = 4'd3,
		PH_INIT_SET2 = 4'd4,
		PH_ST_DEB1   = 4'd5,
		PH_ST_UP     = 4'd6,
		PH_ST_HOLD   = 4'd7,
		PH_ST_DEB2   = 4'd8,
		PH_BT_DEB1   = 4'd9,
		PH_BT_HOLD   = 4'd10,
		PH_BT_DEB2   = 4'd11,
		PH_PAUSE     = 4'd12,
		PH_BLINK     = 4'd13,
		PH_ST_DOWN   = 4'd14
	} phase_t;

	// Where a blink sequence goes when it is done.
	typedef enum logic [1:0] {
		AFTER_IDLE     = 2'd0,
		AFTER_ST_DOWN  = 2'd1,
		AFTER_SPARE2   = 2'd2,
		AFTER_SPARE3   = 2'd3
	} after_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_DRIVE_TICKS      = 3'd0;
	localparam logic [2:0] REG_SHORT_WAIT_TICKS = 3'd1;
	localparam logic [2:0] REG_DEBOUNCE_TICKS   = 3'd2;
	localparam logic [2:0] REG_BLINK_HALF_TICKS = 3'd3;
	localparam logic [2:0] REG_SHOW_PAUSE_TICKS = 3'd4;
	localparam logic [2:0] REG_MAX_COUNT        = 3'd5;
	localparam logic [2:0] REG_SAVED_COUNT      = 3'd6;
	localparam logic [2:0] REG_SAVED_VALID      = 3'd7;

	// Register reset values.
	localparam logic [15:0] RST_DRIVE_TICKS      = 16'd800;
	localparam logic [7:0]  RST_SHORT_WAIT_TICKS = 8'd10;
	localparam logic [7:0]  RST_DEBOUNCE_TICKS   = 8'd30;
	localparam logic [15:0] RST_BLINK_HALF_TICKS = 16'd300;
	localparam logic [15:0] RST_SHOW_PAUSE_TICKS = 16'd1000;
	localparam logic [7:0]  RST_MAX_COUNT        = 8'd10;
	localparam logic [7:0]  RST_SAVED_COUNT      = 8'd1;

	// One tick of pin levels.
	typedef struct packed {
		logic starter_low;
		logic button_low;
	} tick_t;

	// One result per tick.
	typedef struct packed {
		logic       drive_up;
		logic       drive_down;
		logic       led_on;
		logic [7:0] count_value;
		logic       count_store;
		logic [3:0] phase_code;
	} result_t;

	// One register write.
	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] value;
	} cfg_t;

endpackage
`default_nettype wire

/* hdl/cas_stream_if.sv */
// Valid/ready channel interface used for ticks, results and register writes.
`default_nettype none
interface cas_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/choke_actuator_sequencer.sv */
// Choke actuator sequencer: debounced starter and button control of an up/down actuator.
//
// Usage: each transaction on the tick channel is one 1 ms tick carrying the
// starter and button pin levels. Every tick produces exactly one transaction on
// the result channel with the up and down drives, the LED, the selected count,
// a store pulse for nonvolatile storage and the current phase code.
// The cfg channel writes the eight timing and count registers; it is always
// ready and should only be used while no result is pending.
// A tick accepted at one edge has its result registered and valid after that
// edge. Throughput is one tick per cycle while the receiver takes each result,
// set by the single phase/timer update between the tick and the result register.
// The tick channel stays ready while the result register is empty or is being
// taken in the same cycle; a stalled receiver holds the result and stalls ticks.
// After reset the registers take their default values and the sequencer starts
// in the start-up drive up phase with the count at one.
`default_nettype none
module choke_actuator_sequencer #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cas_stream_if.sink   tick,
	cas_stream_if.source result,
	cas_stream_if.sink   cfg
);

	localparam int LW = TIMER_WIDTH + 16;
	localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

	// Configuration registers.
	logic [15:0] drive_ticks_q, blink_half_ticks_q, show_pause_ticks_q;
	logic [7:0]  short_wait_ticks_q, debounce_ticks_q, max_count_q, saved_count_q;
	logic        saved_valid_q;

	// Sequencer state.
	cas_pkg::phase_t         phase_q, phase_d;
	logic [TIMER_WIDTH-1:0]  timer_q, timer_d, timer_inc;
	logic [7:0]              count_q, count_d, blinks_q, blinks_d;
	logic                    lit_q, lit_d;
	cas_pkg::after_t         after_q, after_d;
	logic                    store;

	// Result register.
	logic              res_valid_q;
	cas_pkg::result_t  res_data_q, res_d;

	logic              tick_acc;
	logic [15:0]       dur;
	logic [LW-1:0]     lim_w;
	logic [TIMER_WIDTH-1:0] lim;
	logic              done;
	logic [8:0]        next_count;
	logic              st, bt;

	assign cfg.ready    = 1'b1;
	assign tick.ready   = !res_valid_q || result.ready;
	assign tick_acc     = tick.valid && tick.ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_data_q;
	assign st = tick.data.starter_low;
	assign bt = tick.data.button_low;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_ticks_q      <= cas_pkg::RST_DRIVE_TICKS;
			short_wait_ticks_q <= cas_pkg::RST_SHORT_WAIT_TICKS;
			debounce_ticks_q   <= cas_pkg::RST_DEBOUNCE_TICKS;
			blink_half_ticks_q <= cas_pkg::RST_BLINK_HALF_TICKS;
			show_pause_ticks_q <= cas_pkg::RST_SHOW_PAUSE_TICKS;
			max_count_q        <= cas_pkg::RST_MAX_COUNT;
			saved_count_q      <= cas_pkg::RST_SAVED_COUNT;
			saved_valid_q      <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				cas_pkg::REG_DRIVE_TICKS:      drive_ticks_q      <= cfg.data.value;
				cas_pkg::REG_SHORT_WAIT_TICKS: short_wait_ticks_q <= cfg.data.value[7:0];
				cas_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_q   <= cfg.data.value[7:0];
				cas_pkg::REG_BLINK_HALF_TICKS: blink_half_ticks_q <= cfg.data.value;
				cas_pkg::REG_SHOW_PAUSE_TICKS: show_pause_ticks_q <= cfg.data.value;
				cas_pkg::REG_MAX_COUNT:        max_count_q        <= cfg.data.value[7:0];
				cas_pkg::REG_SAVED_COUNT:      saved_count_q      <= cfg.data.value[7:0];
				cas_pkg::REG_SAVED_VALID:      saved_valid_q      <= cfg.data.value[0];
				default: ;
			endcase
		end
	end

	// Duration of the current phase.
	always_comb begin
		case (phase_q)
			cas_pkg::PH_INIT_UP, cas_pkg::PH_INIT_DOWN,
			cas_pkg::PH_ST_UP, cas_pkg::PH_ST_DOWN:       dur = drive_ticks_q;
			cas_pkg::PH_INIT_SET1, cas_pkg::PH_INIT_SET2,
			cas_pkg::PH_ST_HOLD, cas_pkg::PH_BT_HOLD:     dur = {8'd0, short_wait_ticks_q};
			cas_pkg::PH_ST_DEB1, cas_pkg::PH_ST_DEB2,
			cas_pkg::PH_BT_DEB1, cas_pkg::PH_BT_DEB2:     dur = {8'd0, debounce_ticks_q};
			cas_pkg::PH_PAUSE:                            dur = show_pause_ticks_q;
			cas_pkg::PH_BLINK:                            dur = blink_half_ticks_q;
			default:                                      dur = 16'd0;
		endcase
	end

	// Phase timer: zero acts as one tick, long durations saturate at the timer range.
	always_comb begin
		lim_w = (dur == 16'd0) ? LW'(1) : LW'(dur);
		if (lim_w > LW'(TMAX)) begin
			lim_w = LW'(TMAX);
		end
		lim       = lim_w[TIMER_WIDTH-1:0];
		timer_inc = (timer_q == TMAX) ? timer_q : timer_q + 1'b1;
		done      = timer_inc >= lim;
	end

	assign next_count = {1'b0, count_q} + 9'd1;

	// Next state of the sequencer for one tick.
	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_inc;
		count_d  = count_q;
		blinks_d = blinks_q;
		lit_d    = lit_q;
		after_d  = after_q;
		store    = 1'b0;
		case (phase_q)
			cas_pkg::PH_IDLE: begin
				timer_d = timer_q;
				if (st) begin
					phase_d = cas_pkg::PH_ST_DEB1;
					timer_d = '0;
				end else if (bt) begin
					phase_d = cas_pkg::PH_BT_DEB1;
					timer_d = '0;
				end
			end
			cas_pkg::PH_INIT_UP: begin
				if (done) begin
					phase_d = cas_pkg::PH_INIT_SET1;
					timer_d = '0;
				end
			end
			cas_pkg::PH_INIT_SET1: begin
				if (done) begin
					phase_d = cas_pkg::PH_INIT_DOWN;
					timer_d = '0;
				end
			end
			cas_pkg::PH_INIT_DOWN: begin
				if (done) begin
					phase_d = cas_pkg::PH_INIT_SET2;
					timer_d = '0;
				end
			end
			cas_pkg::PH_INIT_SET2: begin
				if (done) begin
					timer_d = '0;
					if (!saved_valid_q) begin
						count_d = 8'd1;
						store   = 1'b1;
						phase_d = cas_pkg::PH_IDLE;
					end else begin
						count_d = saved_count_q;
						if (saved_count_q > max_count_q) begin
							count_d = 8'd1;
							store   = 1'b1;
						end
						after_d = cas_pkg::AFTER_IDLE;
						phase_d = cas_pkg::PH_PAUSE;
					end
				end
			end
			cas_pkg::PH_ST_DEB1: begin
				if (done) begin
					timer_d = '0;
					if (st) begin
						phase_d = cas_pkg::PH_ST_UP;
					end else begin
						phase_d = bt ? cas_pkg::PH_BT_DEB1 : cas_pkg::PH_IDLE;
					end
				end
			end
			cas_pkg::PH_ST_UP: begin
				if (done) begin
					timer_d = '0;
					phase_d = st ? cas_pkg::PH_ST_HOLD : cas_pkg::PH_ST_DEB2;
				end
			end
			cas_pkg::PH_ST_HOLD: begin
				if (done) begin
					timer_d = '0;
					if (!st) begin
						phase_d = cas_pkg::PH_ST_DEB2;
					end
				end
			end
			cas_pkg::PH_ST_DEB2: begin
				if (done) begin
					timer_d = '0;
					if (!st) begin
						// Starter released: blink the count if it is not zero, then drive down.
						after_d = cas_pkg::AFTER_ST_DOWN;
						if (count_q == 8'd0) begin
							phase_d = cas_pkg::PH_ST_DOWN;
						end else begin
							blinks_d = count_q;
							lit_d    = 1'b1;
							phase_d  = cas_pkg::PH_BLINK;
						end
					end else begin
						phase_d = bt ? cas_pkg::PH_BT_DEB1 : cas_pkg::PH_IDLE;
					end
				end
			end
			cas_pkg::PH_ST_DOWN: begin
				if (done) begin
					timer_d = '0;
					phase_d = bt ? cas_pkg::PH_BT_DEB1 : cas_pkg::PH_IDLE;
				end
			end
			cas_pkg::PH_BT_DEB1: begin
				if (done) begin
					timer_d = '0;
					phase_d = bt ? cas_pkg::PH_BT_HOLD : cas_pkg::PH_IDLE;
				end
			end
			cas_pkg::PH_BT_HOLD: begin
				if (done) begin
					timer_d = '0;
					if (!bt) begin
						phase_d = cas_pkg::PH_BT_DEB2;
					end
				end
			end
			cas_pkg::PH_BT_DEB2: begin
				if (done) begin
					timer_d = '0;
					if (!bt) begin
						// Button released: advance the count with wrap to one.
						count_d = (next_count > {1'b0, max_count_q}) ? 8'd1 : next_count[7:0];
						store   = 1'b1;
						after_d = cas_pkg::AFTER_IDLE;
						phase_d = cas_pkg::PH_PAUSE;
					end else begin
						phase_d = cas_pkg::PH_IDLE;
					end
				end
			end
			cas_pkg::PH_PAUSE: begin
				if (done) begin
					timer_d = '0;
					if (count_q == 8'd0) begin
						phase_d = (after_q == cas_pkg::AFTER_ST_DOWN) ?
							cas_pkg::PH_ST_DOWN : cas_pkg::PH_IDLE;
					end else begin
						blinks_d = count_q;
						lit_d    = 1'b1;
						phase_d  = cas_pkg::PH_BLINK;
					end
				end
			end
			cas_pkg::PH_BLINK: begin
				if (done) begin
					timer_d = '0;
					if (lit_q) begin
						lit_d = 1'b0;
					end else begin
						blinks_d = blinks_q - 8'd1;
						if (blinks_q == 8'd1) begin
							phase_d = (after_q == cas_pkg::AFTER_ST_DOWN) ?
								cas_pkg::PH_ST_DOWN : cas_pkg::PH_IDLE;
						end else begin
							lit_d = 1'b1;
						end
					end
				end
			end
			default: begin
				phase_d = cas_pkg::PH_IDLE;
				timer_d = '0;
			end
		endcase
	end

	// Result fields: drives, LED and phase from the phase at the start of the tick.
	always_comb begin
		res_d.drive_up    = (phase_q == cas_pkg::PH_INIT_UP) || (phase_q == cas_pkg::PH_ST_UP);
		res_d.drive_down  = (phase_q == cas_pkg::PH_INIT_DOWN) ||
			(phase_q == cas_pkg::PH_ST_DOWN);
		res_d.led_on      = (phase_q == cas_pkg::PH_BLINK) && lit_q;
		res_d.phase_code  = phase_q;
		res_d.count_value = count_d;
		res_d.count_store = store;
	end

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cas_pkg::PH_INIT_UP;
			timer_q  <= '0;
			count_q  <= 8'd1;
			blinks_q <= 8'd0;
			lit_q    <= 1'b0;
			after_q  <= cas_pkg::AFTER_IDLE;
		end else if (tick_acc) begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			count_q  <= count_d;
			blinks_q <= blinks_d;
			lit_q    <= lit_d;
			after_q  <= after_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_acc) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with each accepted tick.
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			res_data_q <= res_d;
		end
	end

endmodule
`default_nettype wire
